// ===== design/response_frame_deframer_defines.svh =====
// Assertion macros for the response frame deframer.
// Included by the top level; no other dependencies.
`ifndef RESPONSE_FRAME_DEFRAMER_DEFINES_SVH
`define RESPONSE_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
`define RFD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfd assertion failed");
`define RFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfd assertion failed");
`else
`define RFD_ASSERT_IMPL(lbl, ante, cons)
`define RFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/rfd_pkg.sv =====
// Shared types and constants of the response frame deframer.
// No dependencies.
package rfd_pkg;

    localparam logic [31:0] SYNC_WORD = 32'hD0F9_EE5D;
    localparam int HDR_BYTES  = 12;
    localparam int HSUM_BYTES = 8;
    localparam int PLEN_W     = 6;

    typedef struct packed {
        logic              push;
        logic [15:0]       command;
        logic [PLEN_W-1:0] payload_length;
        logic [7:0]        payload_byte;
        logic              byte_valid;
        logic              last;
    } emit_t;

endpackage

// ===== design/rfd_ram.sv =====
// Receive buffer RAM: one write port, one registered read port.
// No dependencies.
module rfd_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/rfd_ctrl.sv =====
// Deframing sequencer: circular buffer pointers, sync scan, header and data
// sums through one shared accumulator. Depends on rfd_pkg and rfd_ram.
module rfd_ctrl #(
    parameter int N  = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    min_len,
    input  logic          slot_free,
    output rfd_pkg::emit_t emit
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_HDR, ST_CHECK, ST_DATA, ST_EMIT_RD, ST_EMIT_WAIT, ST_EMPTY
    } state_t;

    localparam logic [CW-1:0] HDR_C = CW'(rfd_pkg::HDR_BYTES);

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic [23:0]   win_reg, win_next;
    logic [63:0]   hdr_reg, hdr_next;
    logic [15:0]   hsum_reg, hsum_next;
    logic [15:0]   acc_reg, acc_next;
    logic [CW-1:0] dlen_reg, dlen_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    q;
    logic [CW-1:0] lim, fill_eff, drop, pos, total;
    logic          do_drop;
    logic [31:0]   win_full;
    logic [15:0]   len16, dl16, acc_sum;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(N))
        begin
            s = s - (CW+1)'(N);
        end
        return s[AW-1:0];
    endfunction

    rfd_ram #(.DEPTH(N), .AW(AW)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (q)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign fill_eff = (fill_reg >= CW'(N)) ? '0 : fill_reg;
    assign win_full = {win_reg, q};
    assign acc_sum  = acc_reg + 16'(q);
    assign len16    = hdr_reg[47:32];
    assign dl16     = len16 - 16'(min_len);
    assign total    = HDR_C + dlen_reg;
    assign wr_en    = (state_reg == ST_IDLE) && in_valid;
    assign wr_addr  = phys(head_reg, fill_eff);

    always_comb
    begin
        unique case (state_reg)
            ST_SCAN: lim = fill_reg;
            ST_HDR:  lim = HDR_C;
            default: lim = total;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        iss_next   = iss_reg;
        pend_next  = 1'b0;
        pidx_next  = iss_reg;
        win_next   = win_reg;
        hdr_next   = hdr_reg;
        hsum_next  = hsum_reg;
        acc_next   = acc_reg;
        dlen_next  = dlen_reg;
        do_drop    = 1'b0;
        drop       = '0;
        pos        = pidx_reg - CW'(3);
        rd_en      = 1'b0;
        rd_addr    = phys(head_reg, iss_reg);
        emit       = '0;
        emit.command        = hdr_reg[63:48];
        emit.payload_length = rfd_pkg::PLEN_W'(dlen_reg);
        emit.payload_byte   = q;
        emit.byte_valid     = 1'b1;

        if ((state_reg == ST_SCAN || state_reg == ST_HDR || state_reg == ST_DATA)
            && iss_reg < lim)
        begin
            rd_en     = 1'b1;
            pend_next = 1'b1;
            iss_next  = iss_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    fill_next  = fill_eff + CW'(1);
                    iss_next   = '0;
                    win_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    win_next = win_full[23:0];
                    if (pidx_reg >= CW'(3) && win_full == rfd_pkg::SYNC_WORD)
                    begin
                        do_drop    = 1'b1;
                        drop       = pos;
                        pend_next  = 1'b0;
                        iss_next   = '0;
                        acc_next   = '0;
                        state_next = (fill_reg - pos < HDR_C) ? ST_IDLE : ST_HDR;
                    end
                    else if (pidx_reg == fill_reg - CW'(1))
                    begin
                        if (fill_reg > CW'(3))
                        begin
                            do_drop = 1'b1;
                            drop    = fill_reg - CW'(3);
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HDR:
            begin
                if (pend_reg)
                begin
                    hdr_next = {hdr_reg[55:0], q};
                    if (pidx_reg < CW'(rfd_pkg::HSUM_BYTES))
                    begin
                        acc_next = acc_sum;
                    end
                    if (pidx_reg == HDR_C - CW'(1))
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                hsum_next = acc_reg;
                acc_next  = '0;
                iss_next  = HDR_C;
                dlen_next = CW'(dl16);
                if (len16 < 16'(min_len) || dl16 > 16'(N - rfd_pkg::HDR_BYTES))
                begin
                    do_drop    = 1'b1;
                    drop       = CW'(1);
                    state_next = ST_IDLE;
                end
                else if (fill_reg < HDR_C + CW'(dl16))
                begin
                    state_next = ST_IDLE;
                end
                else if (dl16 == '0)
                begin
                    if (acc_reg == hdr_reg[31:16] && hdr_reg[15:0] == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        do_drop    = 1'b1;
                        drop       = CW'(1);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (pend_reg)
                begin
                    acc_next = acc_sum;
                    if (pidx_reg == total - CW'(1))
                    begin
                        iss_next = HDR_C;
                        if (acc_sum == hdr_reg[15:0] && hsum_reg == hdr_reg[31:16])
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            do_drop    = 1'b1;
                            drop       = CW'(1);
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (slot_free)
                begin
                    emit.push = 1'b1;
                    emit.last = (iss_reg == total - CW'(1));
                    iss_next  = iss_reg + CW'(1);
                    if (emit.last)
                    begin
                        do_drop    = 1'b1;
                        drop       = total;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMPTY:
            begin
                emit.payload_length = '0;
                emit.payload_byte   = '0;
                emit.byte_valid     = 1'b0;
                emit.last           = 1'b1;
                if (slot_free)
                begin
                    emit.push  = 1'b1;
                    do_drop    = 1'b1;
                    drop       = HDR_C;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        head_next = head_reg;
        if (do_drop)
        begin
            head_next = phys(head_reg, drop);
            fill_next = fill_reg - drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            iss_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            iss_reg   <= iss_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        win_reg  <= win_next;
        hdr_reg  <= hdr_next;
        hsum_reg <= hsum_next;
        acc_reg  <= acc_next;
        dlen_reg <= dlen_next;
    end

endmodule

// ===== design/response_frame_deframer.sv =====
// Response frame deframer top level: configuration register, output register.
// Depends on rfd_pkg, rfd_ctrl and response_frame_deframer_defines.svh.
//
// Takes one received byte at a time into a circular buffer of RX_BUFFER_BYTES
// bytes and, after each byte, searches for the sync word D0 F9 EE 5D, checks
// the 12-byte header and the additive sums, and delivers a good frame as its
// payload bytes (or one item for an empty payload). A byte is taken only while
// in_stall is low; its decode attempt then holds in_stall high through a sync
// scan of the bytes held, the header read, a check step, the data sum and the
// delivery of each payload byte (a RAM read, then a wait for the output slot),
// or one item for an empty payload, plus any time the output is stalled. The
// single read port of the buffer RAM and one shared accumulator pace the scan
// and the sums at one byte a cycle.
`include "response_frame_deframer_defines.svh"

module response_frame_deframer #(
    parameter int RX_BUFFER_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] command,
    output logic [rfd_pkg::PLEN_W-1:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        last
);

    localparam int AW = $clog2(RX_BUFFER_BYTES);
    localparam int CW = $clog2(RX_BUFFER_BYTES + 1);

    logic [7:0]     min_len_reg;
    logic           out_valid_reg;
    logic           slot_free;
    rfd_pkg::emit_t emit;

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    rfd_ctrl #(.N(RX_BUFFER_BYTES), .AW(AW), .CW(CW)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .min_len   (min_len_reg),
        .slot_free (slot_free),
        .emit      (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= 8'd4;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_len_reg <= cfg_data;
            end
            if (emit.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            command        <= emit.command;
            payload_length <= emit.payload_length;
            payload_byte   <= emit.payload_byte;
            byte_valid     <= emit.byte_valid;
            last           <= emit.last;
        end
    end

    `RFD_ASSERT_IMPL(a_push_free, emit.push, slot_free)
    `RFD_ASSERT_IMPL(a_idle_no_push, !in_stall, !emit.push)
    `RFD_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)

endmodule
